>>> rtl/core/smf_pkg.sv
package smf_pkg;

   // Sample and register widths fixed by the data format.
   localparam int SAMPLE_W           = 32;
   localparam int WIN_REG_W          = 4;
   localparam int CSR_DATA_W         = 32;
   localparam int CSR_ADDR_W         = 3;

   // Window limits.
   localparam int MAX_WINDOW_DEFAULT = 9;
   localparam int MIN_WINDOW         = 3;
   localparam logic [WIN_REG_W-1:0] WINDOW_RESET = WIN_REG_W'(5);

   // Register index of the window length register (byte address 4 * index).
   localparam logic REG_WINDOW_LENGTH = 1'b0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROW,
      ST_SCAN,
      ST_DRAIN,
      ST_CHECK,
      ST_EMIT
   } smf_state_type;

   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_ACCEPT,
      CMD_ROW_START,
      CMD_SCAN,
      CMD_CHECK,
      CMD_EMIT
   } smf_cmd_type;

   typedef struct packed {
      logic fill_done;  // the item being accepted completes the window
      logic last_j;     // the scan index sits on the last window entry
      logic pick;       // the current pivot is the median, or it is the last pivot
      logic out_busy;   // the output register still holds an untaken item
   } smf_status_type;

endpackage

>>> rtl/core/smf_req_if.sv
interface smf_req_if import smf_pkg::*;;
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface

>>> rtl/core/smf_rsp_if.sv
interface smf_rsp_if import smf_pkg::*;;
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] filtered_value;
   logic                       window_full;

   modport source (output valid, output filtered_value, output window_full, input ready);
   modport sink (input valid, input filtered_value, input window_full, output ready);
endinterface

>>> rtl/core/smf_ctrl.sv
module smf_ctrl import smf_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  smf_status_type status,
   output smf_cmd_type    cmd
);

   smf_state_type state_ff;
   smf_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = CMD_NONE;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd      = CMD_ACCEPT;
               state_in = status.fill_done ? ST_ROW : ST_EMIT;
            end
         end
         ST_ROW: begin
            cmd      = CMD_ROW_START;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            cmd = CMD_SCAN;
            if (status.last_j) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            cmd      = CMD_CHECK;
            state_in = status.pick ? ST_EMIT : ST_ROW;
         end
         ST_EMIT: begin
            if (!status.out_busy) begin
               cmd      = CMD_EMIT;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> rtl/core/smf_datapath.sv
module smf_datapath import smf_pkg::*; #(
   parameter int MAX_WINDOW = MAX_WINDOW_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  smf_cmd_type                cmd,
   output smf_status_type             status,
   input  logic                       win_wr,
   input  logic [WIN_REG_W-1:0]       win_wdata,
   output logic [WIN_REG_W-1:0]       win_value,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [SAMPLE_W-1:0] rsp_value,
   output logic                       rsp_full
);

   localparam int IDX_W = $clog2(MAX_WINDOW);
   localparam int CNT_W = $clog2(MAX_WINDOW + 1);
   localparam int WMAX  = (MAX_WINDOW - 1) | 1;

   logic signed [SAMPLE_W-1:0] sample_mem [MAX_WINDOW];

   logic [WIN_REG_W-1:0]       window_ff, window_in;
   logic [IDX_W-1:0]           wp_ff, wp_in;
   logic [CNT_W-1:0]           fill_ff, fill_in;
   logic [IDX_W-1:0]           i_ff, i_in;
   logic [IDX_W-1:0]           j_ff, j_in;
   logic [CNT_W-1:0]           less_ff, less_in;
   logic [CNT_W-1:0]           equal_ff, equal_in;
   logic                       cmp_en_ff;
   logic signed [SAMPLE_W-1:0] piv_ff;
   logic signed [SAMPLE_W-1:0] cand_ff;
   logic signed [SAMPLE_W-1:0] res_value_ff, res_value_in;
   logic                       res_full_ff, res_full_in;
   logic signed [SAMPLE_W-1:0] rsp_value_ff, rsp_value_in;
   logic                       rsp_full_ff, rsp_full_in;
   logic                       rsp_valid_ff, rsp_valid_in;

   int                         eff_int;
   logic [CNT_W-1:0]           win_len;
   logic [CNT_W-1:0]           half;
   logic [CNT_W-1:0]           wp_inc;
   logic [CNT_W-1:0]           fill_inc;
   logic                       last_i;
   logic                       is_median;

   // Effective window: clamp to the legal range, then round an even value up.
   always_comb begin
      eff_int = int'(window_ff);
      if (eff_int < MIN_WINDOW) begin
         eff_int = MIN_WINDOW;
      end
      if (eff_int > WMAX) begin
         eff_int = WMAX;
      end
      if (eff_int[0] == 1'b0) begin
         eff_int = eff_int + 1;
      end
   end

   assign win_len   = CNT_W'(eff_int);
   assign half      = win_len >> 1;
   assign wp_inc    = CNT_W'(wp_ff) + CNT_W'(1);
   assign fill_inc  = (fill_ff < win_len) ? fill_ff + CNT_W'(1) : fill_ff;
   assign last_i    = (CNT_W'(i_ff) == win_len - CNT_W'(1));
   assign is_median = (less_ff <= half) && (half < less_ff + equal_ff);

   assign status.fill_done = (fill_inc == win_len);
   assign status.last_j    = (CNT_W'(j_ff) == win_len - CNT_W'(1));
   assign status.pick      = is_median || last_i;
   assign status.out_busy  = rsp_valid_ff;

   always_comb begin
      window_in    = window_ff;
      wp_in        = wp_ff;
      fill_in      = fill_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      less_in      = less_ff;
      equal_in     = equal_ff;
      res_value_in = res_value_ff;
      res_full_in  = res_full_ff;
      rsp_value_in = rsp_value_ff;
      rsp_full_in  = rsp_full_ff;
      rsp_valid_in = rsp_valid_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (cmp_en_ff) begin
         if (cand_ff < piv_ff) begin
            less_in = less_ff + CNT_W'(1);
         end else if (cand_ff == piv_ff) begin
            equal_in = equal_ff + CNT_W'(1);
         end
      end

      unique case (cmd)
         CMD_ACCEPT: begin
            wp_in        = (wp_inc == win_len) ? '0 : wp_inc[IDX_W-1:0];
            fill_in      = fill_inc;
            res_value_in = req_sample;
            res_full_in  = 1'b0;
            i_in         = '0;
         end
         CMD_ROW_START: begin
            j_in     = '0;
            less_in  = '0;
            equal_in = '0;
         end
         CMD_SCAN: begin
            if (!status.last_j) begin
               j_in = j_ff + IDX_W'(1);
            end
         end
         CMD_CHECK: begin
            if (status.pick) begin
               res_value_in = piv_ff;
               res_full_in  = 1'b1;
            end else begin
               i_in = i_ff + IDX_W'(1);
            end
         end
         CMD_EMIT: begin
            rsp_value_in = res_value_ff;
            rsp_full_in  = res_full_ff;
            rsp_valid_in = 1'b1;
         end
         default: begin
         end
      endcase

      // A window change restarts filling from the first store entry.
      if (win_wr) begin
         window_in = win_wdata;
         wp_in     = '0;
         fill_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff    <= WINDOW_RESET;
         wp_ff        <= '0;
         fill_ff      <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         cmp_en_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         window_ff    <= window_in;
         wp_ff        <= wp_in;
         fill_ff      <= fill_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         cmp_en_ff    <= (cmd == CMD_SCAN);
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      less_ff      <= less_in;
      equal_ff     <= equal_in;
      res_value_ff <= res_value_in;
      res_full_ff  <= res_full_in;
      rsp_value_ff <= rsp_value_in;
      rsp_full_ff  <= rsp_full_in;
   end

   // Sample store: one write port, two registered read ports.
   always_ff @(posedge clock) begin
      if (cmd == CMD_ACCEPT) begin
         sample_mem[wp_ff] <= req_sample;
      end
      piv_ff  <= sample_mem[i_ff];
      cand_ff <= sample_mem[j_ff];
   end

   assign win_value = window_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_value = rsp_value_ff;
   assign rsp_full  = rsp_full_ff;

endmodule

>>> rtl/core/sliding_median_filter.sv
// While the window fills, a sample reaches the result register in the cycle after it is
// accepted. With a full window of W entries the median takes up to W ranking passes, each
// through the row start, the scan of every entry, a drain and a check state.
// The filter handles one item at a time, bound by the single shared comparator, and it stalls
// while the previous result has not been taken.
// Reset is synchronous and active high; the window returns to 5 and the fill starts over.
module sliding_median_filter import smf_pkg::*; #(
   parameter int MAX_WINDOW = MAX_WINDOW_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   smf_req_if.sink               req_chan,
   smf_rsp_if.source             rsp_chan,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   // The median is found by ranking: each stored sample in turn becomes the
   // pivot, every sample of the window is compared against it, and the pivot
   // whose count of smaller and equal entries straddles the middle rank is
   // the median. The controller sequences the passes; the datapath holds the
   // ring store, the counters and the result register.

   smf_cmd_type          cmd;
   smf_status_type       status;
   logic                 win_wr;
   logic                 reg_index;
   logic [WIN_REG_W-1:0] win_value;

   // The register file holds one register, so the index is the address word.
   assign reg_index = paddr[CSR_ADDR_W-1];
   assign pready    = 1'b1;
   assign win_wr    = psel && penable && pwrite && (reg_index == REG_WINDOW_LENGTH);

   always_comb begin
      prdata = '0;
      if (reg_index == REG_WINDOW_LENGTH) begin
         prdata = CSR_DATA_W'(win_value);
      end
   end

   smf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .status    (status),
      .cmd       (cmd)
   );

   smf_datapath #(
      .MAX_WINDOW (MAX_WINDOW)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .win_wr     (win_wr),
      .win_wdata  (pwdata[WIN_REG_W-1:0]),
      .win_value  (win_value),
      .req_sample (req_chan.sample),
      .rsp_valid  (rsp_chan.valid),
      .rsp_ready  (rsp_chan.ready),
      .rsp_value  (rsp_chan.filtered_value),
      .rsp_full   (rsp_chan.window_full)
   );

endmodule
